@@ hw/rtl/cv_to_hue_brightness_mapper_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hue and brightness mapper
// Concurrent checks, clocked on the rising edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CV_TO_HUE_BRIGHTNESS_MAPPER_MACROS_SVH
`define CV_TO_HUE_BRIGHTNESS_MAPPER_MACROS_SVH

// Same-cycle implication.
`define CVHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CVHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cvhb_pkg.sv @@
// ----------------------------------------------------------------------------
// cvhb_pkg
// Shared widths, constants and types of the hue and brightness mapper.
// ----------------------------------------------------------------------------
package cvhb_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned SampleMax = 1023;
  localparam int unsigned HueW     = 8;
  localparam int unsigned ScaleW   = 2;
  localparam int unsigned BrightW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Folding of the average into the hue range.
  localparam int unsigned FoldW       = 7;
  localparam int unsigned FoldQuoW    = 4;
  localparam int unsigned FoldRecipW  = 11;
  localparam int unsigned FoldShift   = 17;
  localparam logic [SampleW-1:0]    FoldMod     = 10'd70;
  localparam logic [FoldRecipW-1:0] FoldRecip   = 11'd1873;
  localparam logic [SampleW-1:0]    FoldLow     = 10'd5;
  localparam logic [SampleW-1:0]    FoldHigh    = 10'd65;
  localparam logic [FoldW-1:0]      FoldReplace = 7'd70;

  // Register reset values.
  localparam logic [HueW-1:0]    HueOffsetRst = 8'd40;
  localparam logic [ScaleW-1:0]  HueScaleRst  = 2'd2;
  localparam logic [SampleW-1:0] EnvFloorRst  = 10'd40;

  typedef enum logic [CfgIdxW-1:0] {
    RegHueOffset = 2'd0,
    RegHueScale  = 2'd1,
    RegEnvFloor  = 2'd2
  } cvhb_reg_e;

  typedef struct packed {
    logic [HueW-1:0]    hue_offset;
    logic [ScaleW-1:0]  hue_scale;
    logic [SampleW-1:0] envelope_floor;
  } cvhb_cfg_t;

endpackage

@@ hw/rtl/cvhb_if.sv @@
// ----------------------------------------------------------------------------
// cvhb interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface cvhb_in_if import cvhb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] pitch_sample;
  logic [SampleW-1:0] envelope_sample;

  modport source(output valid, output pitch_sample, output envelope_sample, input ready);
  modport sink(input valid, input pitch_sample, input envelope_sample, output ready);
endinterface

interface cvhb_out_if import cvhb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] smoothed_level;
  logic [HueW-1:0]    hue;
  logic [BrightW-1:0] brightness;

  modport source(output valid, output smoothed_level, output hue, output brightness,
                 input ready);
  modport sink(input valid, input smoothed_level, input hue, input brightness,
               output ready);
endinterface

interface cvhb_cfg_if import cvhb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/cvhb_cell.sv @@
// ----------------------------------------------------------------------------
// cvhb_cell
// One window cell: holds a sample and passes it to its neighbor on a shift.
// ----------------------------------------------------------------------------
module cvhb_cell import cvhb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [SampleW-1:0] sample_o
);

  logic [SampleW-1:0] sample_q, sample_d;

  assign sample_d = shift_i ? sample_i : sample_q;
  assign sample_o = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

endmodule

@@ hw/rtl/cvhb_window.sv @@
// ----------------------------------------------------------------------------
// cvhb_window
// Boxcar window as a chain of cells with a running total.
// ----------------------------------------------------------------------------
module cvhb_window import cvhb_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       shift_i,
  input  logic [SampleW-1:0]                         sample_i,
  output logic [$clog2(SampleMax*WINDOW_LEN+1)-1:0]  total_o
);

  localparam int unsigned TotW = $clog2(SampleMax * WINDOW_LEN + 1);

  logic [SampleW-1:0] chain [WINDOW_LEN+1];
  logic [TotW-1:0]    total_q, total_d;

  assign chain[0] = sample_i;

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    cvhb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_i),
      .sample_i (chain[g]),
      .sample_o (chain[g+1])
    );
  end

  // The sample leaving the last cell is the one that drops out of the window.
  always_comb begin
    total_d = total_q;
    if (shift_i) begin
      total_d = total_q - TotW'(chain[WINDOW_LEN]) + TotW'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else begin
      total_q <= total_d;
    end
  end

  assign total_o = total_q;

endmodule

@@ hw/rtl/cvhb_map.sv @@
// ----------------------------------------------------------------------------
// cvhb_map
// Pipeline from window total and envelope to level, hue and brightness.
// ----------------------------------------------------------------------------
module cvhb_map import cvhb_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      adv_i,
  input  logic                                      fire_i,
  input  logic [SampleW-1:0]                        envelope_i,
  input  cvhb_cfg_t                                 cfg_i,
  input  logic [$clog2(SampleMax*WINDOW_LEN+1)-1:0] total_i,
  output logic                                      valid_o,
  output logic [SampleW-1:0]                        level_o,
  output logic [HueW-1:0]                           hue_o,
  output logic [BrightW-1:0]                        bright_o
);

  localparam int unsigned TotW       = $clog2(SampleMax * WINDOW_LEN + 1);
  localparam int unsigned RecipShift = TotW + $clog2(WINDOW_LEN);
  localparam int unsigned ProdW      = TotW + RecipShift + 1;
  // Rounded-up reciprocal of the window length; exact for every total.
  localparam logic [RecipShift:0] Recip = (RecipShift + 1)'(
    ((64'd1 << RecipShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam int unsigned FoldProdW  = SampleW + FoldRecipW;

  // Stage A: window total is valid, envelope gated.
  logic               va_q;
  logic [BrightW-1:0] bright_a_q;
  logic [SampleW-1:0] env_gated;

  // Stage B: average.
  logic               vb_q;
  logic [SampleW-1:0] avg_b_q;
  logic [BrightW-1:0] bright_b_q;
  logic [ProdW-1:0]   avg_prod;

  // Stage C: quotient of the average by the fold modulus.
  logic                vc_q;
  logic [SampleW-1:0]  avg_c_q;
  logic [FoldQuoW-1:0] quo_c_q;
  logic [BrightW-1:0]  bright_c_q;
  logic [FoldProdW-1:0] fold_prod;

  // Output stage.
  logic                     out_valid_q;
  logic [SampleW-1:0]       level_q;
  logic [HueW-1:0]          hue_q, hue_d;
  logic [BrightW-1:0]       bright_q;
  logic [SampleW-1:0]       quo_mul;
  logic [SampleW-1:0]       rem;
  logic [FoldW-1:0]         folded;
  logic [HueW:0]            hue_sum;
  logic [HueW+ScaleW:0]     hue_prod;

  assign env_gated = (envelope_i < cfg_i.envelope_floor) ? '0 : envelope_i;

  assign avg_prod = {{(RecipShift + 1){1'b0}}, total_i} * {{TotW{1'b0}}, Recip};

  assign fold_prod = {{FoldRecipW{1'b0}}, avg_b_q} * {{SampleW{1'b0}}, FoldRecip};

  always_comb begin
    quo_mul  = {{(SampleW - FoldQuoW){1'b0}}, quo_c_q} * FoldMod;
    rem      = avg_c_q - quo_mul;
    if (rem < FoldLow || rem > FoldHigh) begin
      folded = FoldReplace;
    end else begin
      folded = rem[FoldW-1:0];
    end
    hue_sum  = {{(HueW + 1 - FoldW){1'b0}}, folded} + {1'b0, cfg_i.hue_offset};
    hue_prod = {{ScaleW{1'b0}}, hue_sum} * {{(HueW + 1){1'b0}}, cfg_i.hue_scale};
    hue_d    = hue_prod[HueW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      va_q        <= fire_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      out_valid_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bright_a_q <= env_gated[SampleW-1 -: BrightW];
      avg_b_q    <= avg_prod[RecipShift +: SampleW];
      bright_b_q <= bright_a_q;
      avg_c_q    <= avg_b_q;
      quo_c_q    <= fold_prod[FoldShift +: FoldQuoW];
      bright_c_q <= bright_b_q;
      level_q    <= avg_c_q;
      hue_q      <= hue_d;
      bright_q   <= bright_c_q;
    end
  end

  assign valid_o  = out_valid_q;
  assign level_o  = level_q;
  assign hue_o    = hue_q;
  assign bright_o = bright_q;

endmodule

@@ hw/rtl/cv_to_hue_brightness_mapper.sv @@
// ----------------------------------------------------------------------------
// cv_to_hue_brightness_mapper
// Smooths pitch samples over a boxcar window and maps them to hue and level;
// gates the envelope into a brightness value.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one pitch and one envelope sample per beat. out_o returns
//   one beat per input beat, in order: smoothed level, hue and brightness.
//   cfg_i writes hue_offset (index 0), hue_scale (1) and envelope_floor (2);
//   other indexes are ignored. Write registers only while the block is idle.
//   Throughput is one beat per cycle; the window is a chain of WINDOW_LEN
//   cells that shifts once per beat and updates the running total in the
//   same cycle, followed by two pipeline stages (average, fold quotient)
//   and an output register that takes the hue.
//   At reset the window and its total clear to zero, registers take their
//   default values and the pipeline empties. While the receiver holds ready
//   low with a result waiting, the whole pipeline freezes and in_i.ready
//   drops; bubbles are otherwise taken in without loss of rate.
// ----------------------------------------------------------------------------
`include "cv_to_hue_brightness_mapper_macros.svh"

module cv_to_hue_brightness_mapper import cvhb_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cvhb_in_if.sink    in_i,
  cvhb_out_if.source out_o,
  cvhb_cfg_if.sink   cfg_i
);

  localparam int unsigned TotW = $clog2(SampleMax * WINDOW_LEN + 1);

  cvhb_cfg_t       cfg_q, cfg_d;
  logic            adv;
  logic            in_fire;
  logic            cfg_fire;
  logic [TotW-1:0] total;

  assign adv         = !out_o.valid || out_o.ready;
  assign in_i.ready  = adv;
  assign in_fire     = in_i.valid && adv;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      unique case (cfg_i.index)
        RegHueOffset: cfg_d.hue_offset     = cfg_i.data[HueW-1:0];
        RegHueScale:  cfg_d.hue_scale      = cfg_i.data[ScaleW-1:0];
        RegEnvFloor:  cfg_d.envelope_floor = cfg_i.data[SampleW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_offset     <= HueOffsetRst;
      cfg_q.hue_scale      <= HueScaleRst;
      cfg_q.envelope_floor <= EnvFloorRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cvhb_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_fire),
    .sample_i (in_i.pitch_sample),
    .total_o  (total)
  );

  cvhb_map #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .fire_i     (in_fire),
    .envelope_i (in_i.envelope_sample),
    .cfg_i      (cfg_q),
    .total_i    (total),
    .valid_o    (out_o.valid),
    .level_o    (out_o.smoothed_level),
    .hue_o      (out_o.hue),
    .bright_o   (out_o.brightness)
  );

  // An empty output register never holds back the input side.
  `CVHB_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_o.valid, in_i.ready, "input stalled with empty output")
  // A register write alone leaves the window total untouched.
  `CVHB_ASSERT_NEXT(a_cfg_keeps_total, clk_i, rst_ni, cfg_fire && !in_fire, $stable(total), "window total moved on a register write")
  // With a zero scale every hue comes out zero.
  `CVHB_ASSERT_IMP(a_zero_scale_hue, clk_i, rst_ni, out_o.valid && (cfg_q.hue_scale == '0), out_o.hue == '0, "nonzero hue with zero scale")

endmodule

@@ tb/sv/cv_to_hue_brightness_mapper_tb.sv @@
// ----------------------------------------------------------------------------
// cv_to_hue_brightness_mapper_tb
// Drives sample beats into the mapper and checks every result beat against
// a local model of the boxcar window, hue fold and envelope gate, or a row's
// typed result. A directed table comes first: start-up from a cleared window,
// sample extremes and fold edges. Random phases follow, each with its own
// register settings and handshake idling.
// ----------------------------------------------------------------------------
module cv_to_hue_brightness_mapper_tb;
  import cvhb_pkg::*;

  localparam int unsigned WindowLen   = 5;
  localparam int unsigned PipeLatency = 4;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseBeats  = 190;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic [SampleW-1:0] level;
    logic [HueW-1:0]    hue;
    logic [BrightW-1:0] bright;
  } mapped_t;

  typedef struct {
    logic [SampleW-1:0] pitch;
    logic [SampleW-1:0] env;
    bit                 typed;
    mapped_t            result;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;

  cvhb_in_if  in_ch();
  cvhb_out_if out_ch();
  cvhb_cfg_if cfg_ch();

  cv_to_hue_brightness_mapper #(
    .WINDOW_LEN(WindowLen)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Local copy of the block state and registers.
  logic [SampleW-1:0] pitch_window [WindowLen];
  int unsigned        pitch_total;
  int unsigned        oldest_slot;
  logic [HueW-1:0]    offset_reg;
  logic [ScaleW-1:0]  scale_reg;
  logic [SampleW-1:0] floor_reg;

  mapped_t     pending_maps[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned hold_level = 0;

  sample_row_t start_rows[] = '{
    '{10'd0,    10'd0,    1'b1, '{10'd0,    8'd220, 8'd0}},
    '{10'd1023, 10'd1023, 1'b1, '{10'd204,  8'd208, 8'd255}},
    '{10'd1023, 10'd39,   1'b1, '{10'd409,  8'd198, 8'd0}},
    '{10'd1023, 10'd40,   1'b1, '{10'd613,  8'd186, 8'd10}},
    '{10'd1023, 10'd41,   1'b1, '{10'd818,  8'd176, 8'd10}},
    '{10'd1023, 10'd1023, 1'b1, '{10'd1023, 8'd166, 8'd255}},
    '{10'h2AA,  10'h155,  1'b0, '0},
    '{10'h155,  10'h2AA,  1'b0, '0},
    '{10'h2AA,  10'h155,  1'b0, '0},
    '{10'h155,  10'h2AA,  1'b0, '0},
    '{10'd65,   10'd200,  1'b0, '0},
    '{10'd65,   10'd200,  1'b0, '0},
    '{10'd65,   10'd200,  1'b0, '0},
    '{10'd65,   10'd200,  1'b0, '0},
    '{10'd65,   10'd200,  1'b0, '0},
    '{10'd70,   10'd0,    1'b0, '0},
    '{10'd4,    10'd3,    1'b0, '0},
    '{10'd4,    10'd3,    1'b0, '0},
    '{10'd4,    10'd3,    1'b0, '0},
    '{10'd4,    10'd3,    1'b0, '0},
    '{10'd4,    10'd1022, 1'b0, '0},
    '{10'd9,    10'd1021, 1'b0, '0}
  };

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Pushes a pitch sample through the window and maps the result.
  function automatic mapped_t map_sample(logic [SampleW-1:0] pitch, logic [SampleW-1:0] env);
    mapped_t     res;
    int unsigned avg;
    int unsigned fold;
    int unsigned gated;
    pitch_total = pitch_total - pitch_window[oldest_slot] + pitch;
    pitch_window[oldest_slot] = pitch;
    oldest_slot = (oldest_slot + 1) % WindowLen;
    avg  = pitch_total / WindowLen;
    fold = avg % FoldMod;
    if (fold < FoldLow || fold > FoldHigh) begin
      fold = FoldReplace;
    end
    gated = (env < floor_reg) ? 0 : env;
    res.level  = avg[SampleW-1:0];
    res.hue    = HueW'(((fold + offset_reg) * scale_reg) & 8'hFF);
    res.bright = BrightW'((gated / 4) & 8'hFF);
    return res;
  endfunction

  // Called at a falling edge; returns at the next falling edge with valid
  // still high, so writes can follow back to back. The caller drops valid.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      RegHueOffset: offset_reg = data[HueW-1:0];
      RegHueScale:  scale_reg  = data[ScaleW-1:0];
      RegEnvFloor:  floor_reg  = data[SampleW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(logic [SampleW-1:0] pitch, logic [SampleW-1:0] env,
                             bit typed, mapped_t typed_res);
    mapped_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.pitch_sample    <= pitch;
    in_ch.envelope_sample <= env;
    do @(posedge clk_i); while (!in_ch.ready);
    res = map_sample(pitch, env);
    pending_maps.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Mostly uniform pitch, with held streaks that park the average at or near a fold edge.
  task automatic random_sample(output logic [SampleW-1:0] pitch,
                               output logic [SampleW-1:0] env);
    int unsigned pick;
    int          near;
    if (hold_left == 0 && $urandom_range(5) == 0) begin
      pick = $urandom_range(5);
      hold_level = 70 * $urandom_range(14) + ((pick == 0) ? 4 : (pick == 1) ? 5 :
                   (pick == 2) ? 65 : (pick == 3) ? 66 : (pick == 4) ? 69 : 0);
      if (hold_level > SampleMax) hold_level = SampleMax;
      hold_left = $urandom_range(8, 5);
    end
    if (hold_left != 0) begin
      hold_left--;
      pitch = hold_level[SampleW-1:0];
    end else if ($urandom_range(9) == 0) begin
      pitch = $urandom_range(1) ? SampleMax[SampleW-1:0] : '0;
    end else begin
      pitch = SampleW'($urandom_range(SampleMax));
    end
    pick = $urandom_range(9);
    if (pick < 2) begin
      near = int'(floor_reg) + int'($urandom_range(2)) - 1;
      if (near < 0) near = 0;
      if (near > int'(SampleMax)) near = int'(SampleMax);
      env = near[SampleW-1:0];
    end else if (pick == 2) begin
      env = $urandom_range(1) ? SampleMax[SampleW-1:0] : '0;
    end else begin
      env = SampleW'($urandom_range(SampleMax));
    end
  endtask

  task automatic settle;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(negedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    mapped_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got level %0d hue %0d bright %0d",
                 $time, out_ch.smoothed_level, out_ch.hue, out_ch.brightness);
        fail_count++;
      end else begin
        want = pending_maps.pop_front();
        check_field("smoothed_level", want.level, out_ch.smoothed_level);
        check_field("hue", want.hue, out_ch.hue);
        check_field("brightness", want.bright, out_ch.brightness);
      end
    end
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= StallLimit) begin
      $display("%0t: timeout, no beat in %0d cycles", $time, StallLimit);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SampleW-1:0] pitch;
    logic [SampleW-1:0] env;
    rst_ni                = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.pitch_sample    = '0;
    in_ch.envelope_sample = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = RegHueOffset;
    cfg_ch.data           = '0;
    foreach (pitch_window[i]) pitch_window[i] = '0;
    pitch_total = 0;
    oldest_slot = 0;
    offset_reg  = HueOffsetRst;
    scale_reg   = HueScaleRst;
    floor_reg   = EnvFloorRst;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Start-up with reset register values and a cleared window.
    foreach (start_rows[i]) begin
      send_sample(start_rows[i].pitch, start_rows[i].env, start_rows[i].typed,
                  start_rows[i].result);
    end
    in_ch.valid <= 1'b0;
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          write_reg(RegHueOffset, 10'd0);
          write_reg(RegHueScale, 10'd0);
          write_reg(RegEnvFloor, 10'd0);
        end
        1: begin
          write_reg(RegHueOffset, 10'd255);
          write_reg(RegHueScale, 10'd3);
          write_reg(RegEnvFloor, 10'd1023);
        end
        2: begin
          // Upper data bits beyond the register width are dropped.
          write_reg(RegHueOffset, 10'h3C5);
          write_reg(RegHueScale, 10'h3FD);
          write_reg(RegEnvFloor, 10'd512);
          write_reg(RegSpare, 10'h2A5);
        end
        default: begin
          write_reg(RegHueOffset, CfgDataW'($urandom_range(SampleMax)));
          write_reg(RegHueScale, CfgDataW'($urandom_range(SampleMax)));
          write_reg(RegEnvFloor, CfgDataW'($urandom_range(SampleMax)));
          write_reg(RegSpare, CfgDataW'($urandom_range(SampleMax)));
        end
      endcase
      cfg_ch.valid <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (PhaseBeats) begin
        random_sample(pitch, env);
        send_sample(pitch, env, 1'b0, '0);
      end
      in_ch.valid <= 1'b0;
      settle();
    end

    repeat (4 * PipeLatency) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cvhb_pkg.sv
hw/rtl/cvhb_if.sv
hw/rtl/cvhb_cell.sv
hw/rtl/cvhb_window.sv
hw/rtl/cvhb_map.sv
hw/rtl/cv_to_hue_brightness_mapper.sv
tb/sv/cv_to_hue_brightness_mapper_tb.sv
